FILE: sv/table_driven_fsm_sequencer_top_macros.svh
// assertion macros used by the sequencer's port-level checker
`ifndef TABLE_DRIVEN_FSM_SEQUENCER_TOP_MACROS_SVH
`define TABLE_DRIVEN_FSM_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TDFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during reset
`define TDFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed: next-cycle implication");

`endif

FILE: sv/tdfs_pkg.sv
// shared types, codes and constants of the table driven sequencer
package tdfs_pkg;

    // fixed field widths
    localparam int ST_W    = 4;
    localparam int ID_W    = 4;
    localparam int CLIP_W  = 8;
    localparam int TICK_W  = 16;
    localparam int FLAG_W  = 16;
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // table entry widths
    localparam int TRIG_E_W = ID_W + ST_W;
    localparam int ACT_E_W  = ID_W + CLIP_W;

    // results per item
    localparam int OUT_MAX = 4;
    localparam int NRES_W  = $clog2(OUT_MAX + 1);

    // register reset values
    localparam logic [ST_W-1:0]   INITIAL_STATE_RST = '0;
    localparam logic [TICK_W-1:0] SCAN_INTERVAL_RST = 16'd100;

    // parameter defaults
    localparam int NUM_STATES_DEF   = 16;
    localparam int TRIG_SLOTS_DEF   = 4;
    localparam int ACT_SLOTS_DEF    = 4;
    localparam int NUM_TRIG_IDS_DEF = 16;
    localparam int NUM_ACT_IDS_DEF  = 16;

    // item operations
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_WR_TRIG  = 2'd2,
        OP_WR_ACT   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_STATE = 1'b0,
        CFG_SCAN_INTERVAL = 1'b1
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TRIG_RD,
        SEQ_TRIG_CHK,
        SEQ_ACT_RD,
        SEQ_ACT_CHK,
        SEQ_FINISH
    } seq_t;

endpackage

FILE: sv/tdfs_table.sv
// one table memory: single write port, registered read, per-entry valid bits
module tdfs_table
    import tdfs_pkg::*;
#(
    parameter int WIDTH = TRIG_E_W,
    parameter int DEPTH = NUM_STATES_DEF * TRIG_SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // entry valid bits, cleared at reset so unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rvalid_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: sv/table_driven_fsm_sequencer_top.sv
// Table driven state machine sequencer: software loads per-state trigger and action lists,
// then start and tick items walk the machine. Each item is taken alone: in_stall stays high
// from acceptance until the item's last result has been handed to the output register.
// Writes and ticks that do not scan go straight to the closing result. A scan reads the trigger
// table slot by slot, each slot in a read state and then a check state (the table has one read
// port with a registered read), then the new state's action list slot by slot in the same way,
// then gives the closing result; out_stall can hold results back and so stall the walk. At most
// four results carry actions; the final result of each item has last_result set, and an item
// that emits no action gives one result with action_valid low.
module table_driven_fsm_sequencer_top
    import tdfs_pkg::*;
#(
    parameter int NUM_STATES   = NUM_STATES_DEF,
    parameter int TRIG_SLOTS   = TRIG_SLOTS_DEF,
    parameter int ACT_SLOTS    = ACT_SLOTS_DEF,
    parameter int NUM_TRIG_IDS = NUM_TRIG_IDS_DEF,
    parameter int NUM_ACT_IDS  = NUM_ACT_IDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [FLAG_W-1:0]    trigger_flags,
    input  logic [ST_W-1:0]      table_state,
    input  logic [SLOT_W-1:0]    table_slot,
    input  logic [ID_W-1:0]      entry_id,
    input  logic [ST_W-1:0]      entry_next_state,
    input  logic [CLIP_W-1:0]    entry_clip,
    // result items
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 action_valid,
    output logic [ID_W-1:0]      action_code,
    output logic [CLIP_W-1:0]    clip_number,
    output logic [ST_W-1:0]      present_state,
    output logic                 last_result
);

    localparam int TDEPTH = NUM_STATES * TRIG_SLOTS;
    localparam int ADEPTH = NUM_STATES * ACT_SLOTS;
    localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int AA_W   = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int TC_W   = (TRIG_SLOTS > 1) ? $clog2(TRIG_SLOTS) : 1;
    localparam int AC_W   = (ACT_SLOTS > 1) ? $clog2(ACT_SLOTS) : 1;

    // configuration registers
    logic [ST_W-1:0]   init_state_reg, init_state_next;
    logic [TICK_W-1:0] scan_int_reg,   scan_int_next;

    // control state
    seq_t              seq_reg,       seq_next;
    logic [ST_W-1:0]   cur_state_reg, cur_state_next;
    logic [TICK_W-1:0] ticks_reg,     ticks_next;
    logic [TC_W-1:0]   tcnt_reg,      tcnt_next;
    logic [AC_W-1:0]   acnt_reg,      acnt_next;
    logic [NRES_W-1:0] nres_reg,      nres_next;
    logic              pend_vld_reg,  pend_vld_next;
    logic              out_vld_reg,   out_vld_next;

    // payload registers
    logic [FLAG_W-1:0] flags_reg,     flags_next;
    logic [ID_W-1:0]   pend_code_reg, pend_code_next;
    logic [CLIP_W-1:0] pend_clip_reg, pend_clip_next;
    logic              o_act_reg,     o_act_next;
    logic [ID_W-1:0]   o_code_reg,    o_code_next;
    logic [CLIP_W-1:0] o_clip_reg,    o_clip_next;
    logic [ST_W-1:0]   o_state_reg,   o_state_next;
    logic              o_last_reg,    o_last_next;

    // table ports
    logic                tw_en, aw_en;
    logic [TA_W-1:0]     tw_addr, tr_addr;
    logic [AA_W-1:0]     aw_addr, ar_addr;
    logic [TRIG_E_W-1:0] t_entry;
    logic [ACT_E_W-1:0]  a_entry;

    // handshake and decode
    logic              in_acc, out_acc, out_free;
    op_t               op;
    logic [TICK_W-1:0] ticks_inc;
    logic              scan_hit;
    logic [ID_W-1:0]   t_id, a_id;
    logic [ST_W-1:0]   t_nxt;
    logic [CLIP_W-1:0] a_clip;
    logic              take;
    logic              push;
    logic              push_act;
    logic [ID_W-1:0]   push_code;
    logic [CLIP_W-1:0] push_clip;
    logic              push_last;

    assign in_stall = (seq_reg != SEQ_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_vld_reg && !out_stall;
    assign out_free = !out_vld_reg || !out_stall;
    assign op       = op_t'(operation);

    // table write addressing, out-of-range writes dropped
    assign tw_addr = TA_W'(32'(table_state) * TRIG_SLOTS + 32'(table_slot));
    assign aw_addr = AA_W'(32'(table_state) * ACT_SLOTS + 32'(table_slot));
    assign tw_en   = in_acc && (op == OP_WR_TRIG) && (32'(table_state) < NUM_STATES)
                     && (32'(table_slot) < TRIG_SLOTS);
    assign aw_en   = in_acc && (op == OP_WR_ACT) && (32'(table_state) < NUM_STATES)
                     && (32'(table_slot) < ACT_SLOTS);

    // table read addressing follows the slot counters
    assign tr_addr = TA_W'(32'(cur_state_reg) * TRIG_SLOTS + 32'(tcnt_reg));
    assign ar_addr = AA_W'(32'(cur_state_reg) * ACT_SLOTS + 32'(acnt_reg));

    tdfs_table #(
        .WIDTH (TRIG_E_W),
        .DEPTH (TDEPTH)
    ) u_trig_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tw_en),
        .wr_addr (tw_addr),
        .wr_data ({entry_next_state, entry_id}),
        .rd_addr (tr_addr),
        .rd_data (t_entry)
    );

    tdfs_table #(
        .WIDTH (ACT_E_W),
        .DEPTH (ADEPTH)
    ) u_act_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (aw_en),
        .wr_addr (aw_addr),
        .wr_data ({entry_clip, entry_id}),
        .rd_addr (ar_addr),
        .rd_data (a_entry)
    );

    // entry fields
    assign t_id   = t_entry[ID_W-1:0];
    assign t_nxt  = t_entry[TRIG_E_W-1:ID_W];
    assign a_id   = a_entry[ID_W-1:0];
    assign a_clip = a_entry[ACT_E_W-1:ID_W];

    // saturating tick count and scan decision
    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign scan_hit  = (ticks_inc >= scan_int_reg);

    // configuration writes
    always_comb
    begin
        init_state_next = init_state_reg;
        scan_int_next   = scan_int_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INITIAL_STATE: init_state_next = cfg_data[ST_W-1:0];
                CFG_SCAN_INTERVAL: scan_int_next   = cfg_data[TICK_W-1:0];
                default:           init_state_next = init_state_reg;
            endcase
        end
    end

    // sequencer next state and result pushes
    always_comb
    begin
        seq_next       = seq_reg;
        cur_state_next = cur_state_reg;
        ticks_next     = ticks_reg;
        tcnt_next      = tcnt_reg;
        acnt_next      = acnt_reg;
        nres_next      = nres_reg;
        pend_vld_next  = pend_vld_reg;
        pend_code_next = pend_code_reg;
        pend_clip_next = pend_clip_reg;
        flags_next     = flags_reg;
        take           = 1'b0;
        push           = 1'b0;
        push_act       = 1'b0;
        push_code      = '0;
        push_clip      = '0;
        push_last      = 1'b0;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_acc)
                begin
                    flags_next    = trigger_flags;
                    tcnt_next     = '0;
                    acnt_next     = '0;
                    nres_next     = '0;
                    pend_vld_next = 1'b0;
                    seq_next      = SEQ_FINISH;
                    case (op)
                        OP_START:
                        begin
                            cur_state_next = init_state_reg;
                            if (32'(init_state_reg) < NUM_STATES)
                            begin
                                seq_next = SEQ_ACT_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            ticks_next = ticks_inc;
                            if (scan_hit)
                            begin
                                ticks_next = '0;
                                if (32'(cur_state_reg) < NUM_STATES)
                                begin
                                    seq_next = SEQ_TRIG_RD;
                                end
                            end
                        end
                        default:
                        begin
                            seq_next = SEQ_FINISH;
                        end
                    endcase
                end
            end

            SEQ_TRIG_RD:
            begin
                seq_next = SEQ_TRIG_CHK;
            end

            // first fired trigger in slot order wins
            SEQ_TRIG_CHK:
            begin
                if (t_id == '0)
                begin
                    seq_next = SEQ_FINISH;
                end
                else if ((32'(t_id) < NUM_TRIG_IDS) && flags_reg[t_id])
                begin
                    cur_state_next = t_nxt;
                    acnt_next      = '0;
                    seq_next       = (32'(t_nxt) < NUM_STATES) ? SEQ_ACT_RD : SEQ_FINISH;
                end
                else if (tcnt_reg == TC_W'(TRIG_SLOTS - 1))
                begin
                    seq_next = SEQ_FINISH;
                end
                else
                begin
                    tcnt_next = tcnt_reg + 1'b1;
                    seq_next  = SEQ_TRIG_RD;
                end
            end

            SEQ_ACT_RD:
            begin
                seq_next = SEQ_ACT_CHK;
            end

            // one action held back so the final one can be marked last
            SEQ_ACT_CHK:
            begin
                if (a_id == '0)
                begin
                    seq_next = SEQ_FINISH;
                end
                else
                begin
                    take = (32'(a_id) < NUM_ACT_IDS) && (nres_reg < NRES_W'(OUT_MAX));
                    if (!(take && pend_vld_reg && !out_free))
                    begin
                        if (take)
                        begin
                            if (pend_vld_reg)
                            begin
                                push      = 1'b1;
                                push_act  = 1'b1;
                                push_code = pend_code_reg;
                                push_clip = pend_clip_reg;
                            end
                            pend_vld_next  = 1'b1;
                            pend_code_next = a_id;
                            pend_clip_next = a_clip;
                            nres_next      = nres_reg + 1'b1;
                        end
                        if (acnt_reg == AC_W'(ACT_SLOTS - 1))
                        begin
                            seq_next = SEQ_FINISH;
                        end
                        else
                        begin
                            acnt_next = acnt_reg + 1'b1;
                            seq_next  = SEQ_ACT_RD;
                        end
                    end
                end
            end

            // closing result: held action or an empty one
            SEQ_FINISH:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    push_act      = pend_vld_reg;
                    push_code     = pend_vld_reg ? pend_code_reg : '0;
                    push_clip     = pend_vld_reg ? pend_clip_reg : '0;
                    push_last     = 1'b1;
                    pend_vld_next = 1'b0;
                    seq_next      = SEQ_IDLE;
                end
            end

            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        o_act_next   = o_act_reg;
        o_code_next  = o_code_reg;
        o_clip_next  = o_clip_reg;
        o_state_next = o_state_reg;
        o_last_next  = o_last_reg;
        if (push)
        begin
            out_vld_next = 1'b1;
            o_act_next   = push_act;
            o_code_next  = push_code;
            o_clip_next  = push_clip;
            o_state_next = cur_state_reg;
            o_last_next  = push_last;
        end
        else if (out_acc)
        begin
            out_vld_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_state_reg <= INITIAL_STATE_RST;
            scan_int_reg   <= SCAN_INTERVAL_RST;
            seq_reg        <= SEQ_IDLE;
            cur_state_reg  <= '0;
            ticks_reg      <= '0;
            tcnt_reg       <= '0;
            acnt_reg       <= '0;
            nres_reg       <= '0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            init_state_reg <= init_state_next;
            scan_int_reg   <= scan_int_next;
            seq_reg        <= seq_next;
            cur_state_reg  <= cur_state_next;
            ticks_reg      <= ticks_next;
            tcnt_reg       <= tcnt_next;
            acnt_reg       <= acnt_next;
            nres_reg       <= nres_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        flags_reg     <= flags_next;
        pend_code_reg <= pend_code_next;
        pend_clip_reg <= pend_clip_next;
        o_act_reg     <= o_act_next;
        o_code_reg    <= o_code_next;
        o_clip_reg    <= o_clip_next;
        o_state_reg   <= o_state_next;
        o_last_reg    <= o_last_next;
    end

    assign out_valid     = out_vld_reg;
    assign action_valid  = o_act_reg;
    assign action_code   = o_code_reg;
    assign clip_number   = o_clip_reg;
    assign present_state = o_state_reg;
    assign last_result   = o_last_reg;

endmodule

FILE: sv/tdfs_checker.sv
// port-level checker for the sequencer and its bind
`include "table_driven_fsm_sequencer_top_macros.svh"

module tdfs_checker
    import tdfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              action_valid,
    input  logic [ID_W-1:0]   action_code,
    input  logic [CLIP_W-1:0] clip_number,
    input  logic              last_result
);

    // an accepted item leaves the block busy in the cycle after acceptance
    `TDFS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a result without an action always closes its item
    `TDFS_ASSERT_NOW(a_empty_is_last, out_valid && !action_valid, last_result)

    // a result without an action carries zero code and clip
    `TDFS_ASSERT_NOW(a_empty_is_zero, out_valid && !action_valid,
        (action_code == '0) && (clip_number == '0))

    // while an item still has results to come, no new item is taken
    `TDFS_ASSERT_NOW(a_more_results_busy, out_valid && !last_result, in_stall)

    // a stalled result stays offered
    `TDFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind table_driven_fsm_sequencer_top tdfs_checker u_tdfs_checker (.*);

FILE: sim/tdfs_sequencer_checker.sv
`timescale 1ns / 1ps
// checker for the table driven sequencer: tracks registers and tables, predicts and compares results
module tdfs_sequencer_checker
    import tdfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [FLAG_W-1:0]    trigger_flags,
    input  logic [ST_W-1:0]      table_state,
    input  logic [SLOT_W-1:0]    table_slot,
    input  logic [ID_W-1:0]      entry_id,
    input  logic [ST_W-1:0]      entry_next_state,
    input  logic [CLIP_W-1:0]    entry_clip,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 action_valid,
    input  logic [ID_W-1:0]      action_code,
    input  logic [CLIP_W-1:0]    clip_number,
    input  logic [ST_W-1:0]      present_state,
    input  logic                 last_result,
    output int                   fail_count,
    output int                   outstanding
);

    // one result item as the block should hand it out
    typedef struct packed {
        logic              act_v;
        logic [ID_W-1:0]   code;
        logic [CLIP_W-1:0] clip;
        logic [ST_W-1:0]   st;
        logic              last;
    } report_t;

    // shadow registers and machine state
    logic [ST_W-1:0]   init_state_reg;
    logic [TICK_W-1:0] interval_reg;
    logic [ST_W-1:0]   cur_state;
    logic [TICK_W-1:0] tick_count;

    // shadow tables
    logic [ID_W-1:0]   trig_id   [NUM_STATES_DEF][TRIG_SLOTS_DEF];
    logic [ST_W-1:0]   trig_next [NUM_STATES_DEF][TRIG_SLOTS_DEF];
    logic [ID_W-1:0]   act_id    [NUM_STATES_DEF][ACT_SLOTS_DEF];
    logic [CLIP_W-1:0] act_clip  [NUM_STATES_DEF][ACT_SLOTS_DEF];

    // results still owed by the block, oldest first
    report_t action_reports [$];

    function automatic void clear_sequencer();
        init_state_reg = INITIAL_STATE_RST;
        interval_reg   = SCAN_INTERVAL_RST;
        cur_state      = '0;
        tick_count     = '0;
        for (int s = 0; s < NUM_STATES_DEF; s++)
        begin
            for (int k = 0; k < TRIG_SLOTS_DEF; k++)
            begin
                trig_id[s][k]   = '0;
                trig_next[s][k] = '0;
            end
            for (int k = 0; k < ACT_SLOTS_DEF; k++)
            begin
                act_id[s][k]   = '0;
                act_clip[s][k] = '0;
            end
        end
        action_reports.delete();
    endfunction

    // single result with no action, closing the item
    function automatic void owe_quiet_result();
        report_t r;
        r.act_v = 1'b0;
        r.code  = '0;
        r.clip  = '0;
        r.st    = cur_state;
        r.last  = 1'b1;
        action_reports.push_back(r);
    endfunction

    // walk the action list of the current state, at most OUT_MAX results
    function automatic void owe_state_actions();
        report_t acts [OUT_MAX];
        report_t r;
        int n;
        n = 0;
        if (cur_state < NUM_STATES_DEF)
        begin
            for (int a = 0; a < ACT_SLOTS_DEF; a++)
            begin
                if (act_id[cur_state][a] == '0)
                    break;
                if (act_id[cur_state][a] < NUM_ACT_IDS_DEF && n < OUT_MAX)
                begin
                    r.act_v = 1'b1;
                    r.code  = act_id[cur_state][a];
                    r.clip  = act_clip[cur_state][a];
                    r.st    = cur_state;
                    r.last  = 1'b0;
                    acts[n] = r;
                    n++;
                end
            end
        end
        if (n == 0)
            owe_quiet_result();
        else
        begin
            acts[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                action_reports.push_back(acts[i]);
        end
    endfunction

    // apply one accepted item to the shadow machine
    function automatic void advance_sequencer(op_t op, logic [FLAG_W-1:0] flags,
                                              logic [ST_W-1:0] ts, logic [SLOT_W-1:0] slot,
                                              logic [ID_W-1:0] id, logic [ST_W-1:0] nxt,
                                              logic [CLIP_W-1:0] clip);
        bit moved;
        moved = 1'b0;
        case (op)
            OP_START:
            begin
                cur_state = init_state_reg;
                owe_state_actions();
            end
            OP_WR_TRIG:
            begin
                if (ts < NUM_STATES_DEF && slot < TRIG_SLOTS_DEF)
                begin
                    trig_id[ts][slot]   = id;
                    trig_next[ts][slot] = nxt;
                end
                owe_quiet_result();
            end
            OP_WR_ACT:
            begin
                if (ts < NUM_STATES_DEF && slot < ACT_SLOTS_DEF)
                begin
                    act_id[ts][slot]   = id;
                    act_clip[ts][slot] = clip;
                end
                owe_quiet_result();
            end
            default:
            begin
                // tick: saturating count, scan once the interval is reached
                if (tick_count != {TICK_W{1'b1}})
                    tick_count++;
                if (tick_count >= interval_reg)
                begin
                    tick_count = '0;
                    if (cur_state < NUM_STATES_DEF)
                    begin
                        for (int t = 0; t < TRIG_SLOTS_DEF; t++)
                        begin
                            if (trig_id[cur_state][t] == '0)
                                break;
                            if (trig_id[cur_state][t] < NUM_TRIG_IDS_DEF &&
                                flags[trig_id[cur_state][t]])
                            begin
                                cur_state = trig_next[cur_state][t];
                                moved = 1'b1;
                                break;
                            end
                        end
                    end
                end
                if (moved)
                    owe_state_actions();
                else
                    owe_quiet_result();
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            clear_sequencer();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_INITIAL_STATE: init_state_reg = cfg_data[ST_W-1:0];
                    CFG_SCAN_INTERVAL: interval_reg   = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting so a stray result never eats a new item's entry
            if (out_valid && !out_stall)
            begin
                if (action_reports.size() == 0)
                begin
                    $error("result item with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = action_reports.pop_front();
                    check_field("action_valid", want.act_v, action_valid);
                    check_field("action_code", want.code, action_code);
                    check_field("clip_number", want.clip, clip_number);
                    check_field("present_state", want.st, present_state);
                    check_field("last_result", want.last, last_result);
                end
            end
            if (in_valid && !in_stall)
                advance_sequencer(op_t'(operation), trigger_flags, table_state, table_slot,
                                  entry_id, entry_next_state, entry_clip);
            outstanding = action_reports.size();
        end
    end

endmodule

FILE: sim/tb_table_driven_fsm_sequencer_top.sv
`timescale 1ns / 1ps
// testbench top for the table driven sequencer: stimulus, stalls, watchdog and verdict
module tb_table_driven_fsm_sequencer_top;
    import tdfs_pkg::*;

    // cycles with no handshake before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      operation;
    logic [FLAG_W-1:0]    trigger_flags;
    logic [ST_W-1:0]      table_state;
    logic [SLOT_W-1:0]    table_slot;
    logic [ID_W-1:0]      entry_id;
    logic [ST_W-1:0]      entry_next_state;
    logic [CLIP_W-1:0]    entry_clip;
    logic                 out_valid;
    logic                 out_stall;
    logic                 action_valid;
    logic [ID_W-1:0]      action_code;
    logic [CLIP_W-1:0]    clip_number;
    logic [ST_W-1:0]      present_state;
    logic                 last_result;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    table_driven_fsm_sequencer_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .trigger_flags    (trigger_flags),
        .table_state      (table_state),
        .table_slot       (table_slot),
        .entry_id         (entry_id),
        .entry_next_state (entry_next_state),
        .entry_clip       (entry_clip),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .action_valid     (action_valid),
        .action_code      (action_code),
        .clip_number      (clip_number),
        .present_state    (present_state),
        .last_result      (last_result)
    );

    tdfs_sequencer_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .trigger_flags    (trigger_flags),
        .table_state      (table_state),
        .table_slot       (table_slot),
        .entry_id         (entry_id),
        .entry_next_state (entry_next_state),
        .entry_clip       (entry_clip),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .action_valid     (action_valid),
        .action_code      (action_code),
        .clip_number      (clip_number),
        .present_state    (present_state),
        .last_result      (last_result),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none in a quiet stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls in random runs
    always @(negedge clk)
    begin
        if (quiet)
        begin
            out_stall  = 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            stall_left = pick_gap();
            out_stall  = (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL table_driven_fsm_sequencer_top");
                $finish;
            end
        end
    end

    // drive one item after a random gap and hold it until taken; returns at a falling edge
    task automatic send_item(op_t op, logic [FLAG_W-1:0] flags, logic [ST_W-1:0] ts,
                             logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                             logic [ST_W-1:0] nxt, logic [CLIP_W-1:0] clip);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        operation        = op;
        trigger_flags    = flags;
        table_state      = ts;
        table_slot       = slot;
        entry_id         = id;
        entry_next_state = nxt;
        entry_clip       = clip;
        in_valid         = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [FLAG_W-1:0] rand_flags();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {FLAG_W{1'b1}};
            2, 3: return FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
            default: return FLAG_W'($urandom);
        endcase
    endfunction

    // zero now and then so lists get cut short
    function automatic logic [ID_W-1:0] rand_id();
        if ($urandom_range(0, 7) == 0)
            return '0;
        return ID_W'($urandom_range(1, 15));
    endfunction

    task automatic write_trigger(logic [ST_W-1:0] ts, logic [SLOT_W-1:0] slot,
                                 logic [ID_W-1:0] id, logic [ST_W-1:0] nxt);
        send_item(OP_WR_TRIG, rand_flags(), ts, slot, id, nxt, CLIP_W'($urandom));
    endtask

    task automatic write_action(logic [ST_W-1:0] ts, logic [SLOT_W-1:0] slot,
                                logic [ID_W-1:0] id, logic [CLIP_W-1:0] clip);
        send_item(OP_WR_ACT, rand_flags(), ts, slot, id, ST_W'($urandom), clip);
    endtask

    task automatic tick(logic [FLAG_W-1:0] flags);
        send_item(OP_TICK, flags, ST_W'($urandom), SLOT_W'($urandom), ID_W'($urandom),
                  ST_W'($urandom), CLIP_W'($urandom));
    endtask

    task automatic start_machine();
        send_item(OP_START, rand_flags(), ST_W'($urandom), SLOT_W'($urandom),
                  ID_W'($urandom), ST_W'($urandom), CLIP_W'($urandom));
    endtask

    // hold the sender until every owed result is out, then let the block settle
    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // table loads with random content, starts, and ticks with varied flags
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            write_trigger(ST_W'($urandom), SLOT_W'($urandom), rand_id(), ST_W'($urandom));
        else if (r < 36)
            write_action(ST_W'($urandom), SLOT_W'($urandom), rand_id(), CLIP_W'($urandom));
        else if (r < 46)
            start_machine();
        else
            tick(rand_flags());
    endtask

    initial
    begin
        int n_items;
        logic [ST_W-1:0] init_st;
        logic [TICK_W-1:0] interval;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_INITIAL_STATE;
        cfg_data         = '0;
        in_valid         = 1'b0;
        operation        = OP_TICK;
        trigger_flags    = '0;
        table_state      = '0;
        table_slot       = '0;
        entry_id         = '0;
        entry_next_state = '0;
        entry_clip       = '0;
        out_stall        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty tables give a bare result, tick far below the interval
        start_machine();
        tick({FLAG_W{1'b1}});
        write_trigger(4'd0, 2'd0, 4'd15, 4'd15);
        write_trigger(4'd0, 2'd1, 4'd1, 4'd5);
        write_trigger(4'd5, 2'd0, 4'd4, 4'd10);
        write_trigger(4'd15, 2'd0, 4'd2, 4'd0);
        write_action(4'd15, 2'd0, 4'd15, 8'hFF);
        write_action(4'd15, 2'd1, 4'd1, 8'h00);
        write_action(4'd15, 2'd2, 4'd8, 8'hAA);
        write_action(4'd15, 2'd3, 4'd7, 8'h55);
        write_action(4'd5, 2'd0, 4'd3, 8'h0F);
        // zero id ends the list, the slot after it stays hidden
        write_action(4'd5, 2'd1, 4'd0, 8'hC3);
        write_action(4'd5, 2'd2, 4'd9, 8'h33);

        // every tick scans: misses, bit 0 alone, a move with one action, a move to no actions
        drain();
        write_reg(CFG_INITIAL_STATE, '0);
        write_reg(CFG_SCAN_INTERVAL, '0);
        tick('0);
        tick(16'h0001);
        tick(16'h0002);
        tick(16'h8000);
        tick(16'h0010);

        // four actions on start, and a start between ticks leaves the count alone
        drain();
        write_reg(CFG_INITIAL_STATE, CFG_W'(15));
        write_reg(CFG_SCAN_INTERVAL, CFG_W'(3));
        start_machine();
        tick({FLAG_W{1'b1}});
        tick({FLAG_W{1'b1}});
        start_machine();
        tick({FLAG_W{1'b1}});
        tick(16'h8000);

        // random phases under several settings
        for (int p = 0; p < 8; p++)
        begin
            n_items = 60;
            init_st = ST_W'($urandom);
            case (p)
                0: begin init_st = '0; interval = 16'd1; end
                1: interval = '0;
                2: begin init_st = 4'd15; interval = 16'd2; end
                3: begin interval = {TICK_W{1'b1}}; n_items = 30; end
                4: interval = 16'd1;
                5: interval = TICK_W'($urandom_range(0, 4));
                6: interval = 16'd3;
                default: begin init_st = 4'd7; interval = '0; end
            endcase
            drain();
            write_reg(CFG_INITIAL_STATE, CFG_W'(init_st));
            write_reg(CFG_SCAN_INTERVAL, interval);
            quiet = (p == 2);
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 99) < 3)
                    drain();
                random_item();
            end
            quiet = 1'b0;
        end

        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("PASS table_driven_fsm_sequencer_top");
        else
            $display("FAIL table_driven_fsm_sequencer_top");
        $finish;
    end

endmodule
